// ----- sv/tcacw_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the text console writer
// no dependencies
package tcacw_pkg;

  // screen geometry
  localparam int unsigned SCREEN_COLS = 80;
  localparam int unsigned SCREEN_ROWS = 25;
  localparam int unsigned CELLS       = SCREEN_COLS * SCREEN_ROWS;

  // cell offsets and cursor are 11 bits, columns fit a byte
  localparam int unsigned CUR_W = 11;
  localparam int unsigned COL_W = 8;

  // byte codes
  localparam logic [7:0] BYTE_ESC       = 8'h1B;
  localparam logic [7:0] BYTE_LBRACKET  = 8'h5B;
  localparam logic [7:0] BYTE_M         = 8'h6D;
  localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;
  localparam logic [7:0] BYTE_BACKSPACE = 8'h08;
  localparam logic [7:0] BYTE_ERRMARK   = 8'h45;
  localparam logic [7:0] BYTE_SPACE     = 8'h20;
  localparam logic [7:0] BYTE_DIGIT_LO  = 8'h30;
  localparam logic [7:0] BYTE_DIGIT_HI  = 8'h39;

  // select graphic rendition codes
  localparam logic [7:0] CODE_RESET  = 8'd0;
  localparam logic [7:0] CODE_FG_LO  = 8'd30;
  localparam logic [7:0] CODE_FG_HI  = 8'd37;
  localparam logic [7:0] CODE_SAT    = 8'd255;

  // register reset values
  localparam logic [7:0]  DEFAULT_ATTR_RST = 8'd7;
  localparam logic [31:0] FG_MAP_RST       = 32'd1934713408;
  localparam logic [7:0]  ERROR_ATTR_RST   = 8'd64;

  // register indexes (byte address bits 3:2)
  localparam logic [1:0] REG_DEFAULT_ATTR = 2'd0;
  localparam logic [1:0] REG_FG_MAP       = 2'd1;
  localparam logic [1:0] REG_ERROR_ATTR   = 2'd2;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_ESC,
    MODE_CSI
  } mode_e;

  typedef struct packed {
    logic [7:0]  default_attr;
    logic [31:0] fg_map;
    logic [7:0]  error_attr;
  } cfg_t;

  typedef struct packed {
    logic             write_enable;
    logic [CUR_W-1:0] cell_index;
    logic [7:0]       glyph;
    logic [7:0]       attribute;
    logic [CUR_W-1:0] cursor_pos;
    logic             error_flag;
  } res_t;

endpackage

// ----- sv/tcacw_core.sv -----
`timescale 1ns / 1ps
// escape parser, attribute and cursor state; one result per accepted byte
// depends on tcacw_pkg
module tcacw_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        char_byte_i,
  input  logic              set_position_i,
  input  logic [7:0]        pos_x_i,
  input  logic [7:0]        pos_y_i,
  input  tcacw_pkg::cfg_t   cfg_i,
  output tcacw_pkg::res_t   result_o
);
  import tcacw_pkg::*;

  mode_e            mode_q, mode_d, mode_eff;
  logic [7:0]       accum_q, accum_d;
  logic [7:0]       attr_q, attr_d;
  logic [CUR_W-1:0] cursor_q, cursor_d, cur_eff;
  logic [COL_W-1:0] col_q, col_d, col_eff;

  logic             pos_in_range;
  logic [15:0]      pos_lin;
  logic             do_text;
  logic [11:0]      accum_wide;
  logic [7:0]       code_off;
  logic [2:0]       nib_sel;
  logic [3:0]       fg_nib;
  logic             is_digit;
  res_t             res;

  assign pos_in_range = (pos_x_i < 8'(SCREEN_COLS)) && (pos_y_i < 8'(SCREEN_ROWS));
  assign pos_lin      = 16'(pos_y_i) * 16'(SCREEN_COLS) + 16'(pos_x_i);
  assign is_digit     = (char_byte_i >= BYTE_DIGIT_LO) && (char_byte_i <= BYTE_DIGIT_HI);
  assign accum_wide   = 12'(accum_q) * 12'd10 + 12'(char_byte_i[3:0]);
  assign code_off     = accum_q - CODE_FG_LO;
  assign nib_sel      = code_off[2:0];
  assign fg_nib       = cfg_i.fg_map[{nib_sel, 2'b00} +: 4];

  always_comb begin
    // a new start position also drops any open escape sequence
    if (set_position_i) begin
      mode_eff = MODE_TEXT;
      cur_eff  = pos_in_range ? pos_lin[CUR_W-1:0] : CUR_W'(CELLS);
      col_eff  = pos_x_i;
    end else begin
      mode_eff = mode_q;
      cur_eff  = cursor_q;
      col_eff  = col_q;
    end

    mode_d   = MODE_TEXT;
    accum_d  = accum_q;
    attr_d   = attr_q;
    cursor_d = cur_eff;
    col_d    = col_eff;
    do_text  = 1'b0;
    res      = '0;

    unique case (mode_eff)
      MODE_ESC: begin
        if (char_byte_i == BYTE_LBRACKET) begin
          mode_d  = MODE_CSI;
          accum_d = '0;
        end else begin
          do_text = 1'b1;
        end
      end
      MODE_CSI: begin
        if (is_digit) begin
          mode_d  = MODE_CSI;
          accum_d = (accum_wide > 12'(CODE_SAT)) ? CODE_SAT : accum_wide[7:0];
        end else if (char_byte_i == BYTE_M) begin
          if (accum_q == CODE_RESET) begin
            attr_d = cfg_i.default_attr;
          end else if (accum_q >= CODE_FG_LO && accum_q <= CODE_FG_HI) begin
            attr_d = {attr_q[7:4], fg_nib};
          end
        end else begin
          do_text = 1'b1;
        end
      end
      MODE_TEXT: begin
        do_text = 1'b1;
      end
      default: begin
        do_text = 1'b1;
      end
    endcase

    if (do_text) begin
      priority if (char_byte_i == BYTE_ESC) begin
        mode_d = MODE_ESC;
      end else if (cur_eff >= CUR_W'(CELLS)) begin
        // off screen: mark the last cell, cursor holds
        res.write_enable = 1'b1;
        res.cell_index   = CUR_W'(CELLS - 1);
        res.glyph        = BYTE_ERRMARK;
        res.attribute    = cfg_i.error_attr;
        res.error_flag   = 1'b1;
      end else if (char_byte_i == BYTE_NEWLINE) begin
        cursor_d = cur_eff + (CUR_W'(SCREEN_COLS) - CUR_W'(col_eff));
        col_d    = '0;
      end else if (char_byte_i == BYTE_BACKSPACE) begin
        res.write_enable = 1'b1;
        res.cell_index   = cur_eff;
        res.glyph        = BYTE_SPACE;
        res.attribute    = attr_q;
      end else begin
        res.write_enable = 1'b1;
        res.cell_index   = cur_eff;
        res.glyph        = char_byte_i;
        res.attribute    = attr_q;
        cursor_d         = cur_eff + CUR_W'(1);
        col_d            = (col_eff == COL_W'(SCREEN_COLS - 1)) ? '0 : col_eff + COL_W'(1);
      end
    end

    res.cursor_pos = cursor_d;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_TEXT;
      accum_q  <= '0;
      attr_q   <= DEFAULT_ATTR_RST;
      cursor_q <= '0;
      col_q    <= '0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      accum_q  <= accum_d;
      attr_q   <= attr_d;
      cursor_q <= cursor_d;
      col_q    <= col_d;
    end
  end

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= CUR_W'(CELLS))
    else $error("cursor beyond end of screen");

  a_col_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cursor_q < CUR_W'(CELLS)) |-> (col_q < COL_W'(SCREEN_COLS)))
    else $error("column out of range while on screen");

  a_esc_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !set_position_i && mode_q == MODE_TEXT && char_byte_i == BYTE_ESC)
      |=> (mode_q == MODE_ESC))
    else $error("escape byte did not open a sequence");

  a_cursor_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && result_o.error_flag) |=> (cursor_q == CUR_W'(CELLS)))
    else $error("cursor moved on off-screen byte");

endmodule

// ----- sv/tcacw_skid.sv -----
`timescale 1ns / 1ps
// two-entry result buffer: output register plus skid register
// depends on tcacw_pkg
module tcacw_skid (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tcacw_pkg::res_t push_data_i,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output tcacw_pkg::res_t out_data_o,
  output logic            full_o
);
  import tcacw_pkg::*;

  logic main_valid_q, main_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t main_q, main_d;
  res_t skid_q, skid_d;
  logic pop;
  logic main_free;

  assign pop       = main_valid_q && !out_stall_i;
  assign main_free = !main_valid_q || pop;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (main_free) begin
      // skid entry is older than any new request
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = push_data_i;
        main_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;
  assign full_o      = skid_valid_q;

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry without output entry");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(main_valid_q && out_stall_i && push_i))
    else $error("skid filled without a stalled output");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("request taken while buffer full");

endmodule

// ----- sv/text_console_ansi_color_writer.sv -----
`timescale 1ns / 1ps
// a byte's result is registered in the output register, or in the skid entry while the output is stalled
// throughput: one byte per cycle while the buffer is not full; parser and cursor update are combinational logic
// an output stall parks one result in the skid entry; the input stalls while it is full
// reset: parser to text, cursor to 0, attribute and registers to their reset values
// top level: apb register file, console core and result buffer; uses tcacw_pkg
module text_console_ansi_color_writer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte stream
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_byte_i,
  input  logic        set_position_i,
  input  logic [7:0]  pos_x_i,
  input  logic [7:0]  pos_y_i,
  // cell writes
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        write_enable_o,
  output logic [tcacw_pkg::CUR_W-1:0] cell_index_o,
  output logic [7:0]  glyph_o,
  output logic [7:0]  attribute_o,
  output logic [tcacw_pkg::CUR_W-1:0] cursor_pos_o,
  output logic        error_flag_o
);
  import tcacw_pkg::*;

  cfg_t cfg_q;
  logic cfg_wr;
  logic in_accept;
  res_t core_res;
  res_t out_res;
  logic buf_full;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_attr <= DEFAULT_ATTR_RST;
      cfg_q.fg_map       <= FG_MAP_RST;
      cfg_q.error_attr   <= ERROR_ATTR_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_DEFAULT_ATTR: cfg_q.default_attr <= pwdata[7:0];
        REG_FG_MAP:       cfg_q.fg_map       <= pwdata;
        REG_ERROR_ATTR:   cfg_q.error_attr   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEFAULT_ATTR: prdata = 32'(cfg_q.default_attr);
      REG_FG_MAP:       prdata = cfg_q.fg_map;
      REG_ERROR_ATTR:   prdata = 32'(cfg_q.error_attr);
      default:          prdata = '0;
    endcase
  end

  assign in_stall_o = buf_full;
  assign in_accept  = in_valid_i && !buf_full;

  tcacw_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .char_byte_i    (char_byte_i),
    .set_position_i (set_position_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .cfg_i          (cfg_q),
    .result_o       (core_res)
  );

  tcacw_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (core_res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_res),
    .full_o      (buf_full)
  );

  assign write_enable_o = out_res.write_enable;
  assign cell_index_o   = out_res.cell_index;
  assign glyph_o        = out_res.glyph;
  assign attribute_o    = out_res.attribute;
  assign cursor_pos_o   = out_res.cursor_pos;
  assign error_flag_o   = out_res.error_flag;

endmodule

// ----- test/console_write_checker.sv -----
`timescale 1ns / 1ps
// checker for the text console writer: follows register writes, predicts the
// cell write of every accepted byte and compares each result field by field
// depends on tcacw_pkg
module console_write_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [3:0]                  paddr_i,
  input  logic [31:0]                 pwdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [7:0]                  char_byte_i,
  input  logic                        set_position_i,
  input  logic [7:0]                  pos_x_i,
  input  logic [7:0]                  pos_y_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic                        write_enable_i,
  input  logic [tcacw_pkg::CUR_W-1:0] cell_index_i,
  input  logic [7:0]                  glyph_i,
  input  logic [7:0]                  attribute_i,
  input  logic [tcacw_pkg::CUR_W-1:0] cursor_pos_i,
  input  logic                        error_flag_i,
  output int unsigned                 writes_due_o,
  output int unsigned                 mismatches_o
);
  import tcacw_pkg::*;

  logic [7:0]  dflt_attr;
  logic [31:0] fg_map;
  logic [7:0]  err_attr;
  mode_e       parse_state;
  logic [7:0]  sgr_code;
  logic [7:0]  cur_attr;
  int unsigned cursor;
  res_t        writes_due[$];
  res_t        want;
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;

  assign mismatches_o = mismatch_count;

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned predicted);
    mismatch_count++;
    $display("[%0t] cell write %0d: %s is %0d, predicted %0d",
             $time, results_seen, what, got, predicted);
  endtask

  function automatic res_t predict_cell_write(input logic [7:0] b, input logic load,
                                              input logic [7:0] x, input logic [7:0] y);
    res_t        r;
    bit          consumed;
    int unsigned v;
    r = '0;
    consumed = 1'b0;
    // a new start position also drops any half-parsed sequence
    if (load) begin
      parse_state = MODE_TEXT;
      if (x >= SCREEN_COLS || y >= SCREEN_ROWS) cursor = CELLS;
      else cursor = y * SCREEN_COLS + x;
    end
    case (parse_state)
      MODE_ESC: begin
        if (b == BYTE_LBRACKET) begin
          parse_state = MODE_CSI;
          sgr_code = '0;
          consumed = 1'b1;
        end else begin
          parse_state = MODE_TEXT;
        end
      end
      MODE_CSI: begin
        if (b >= BYTE_DIGIT_LO && b <= BYTE_DIGIT_HI) begin
          v = sgr_code * 10 + (b - BYTE_DIGIT_LO);
          sgr_code = (v > CODE_SAT) ? CODE_SAT : 8'(v);
          consumed = 1'b1;
        end else begin
          parse_state = MODE_TEXT;
          if (b == BYTE_M) begin
            if (sgr_code == CODE_RESET) begin
              cur_attr = dflt_attr;
            end else if (sgr_code >= CODE_FG_LO && sgr_code <= CODE_FG_HI) begin
              cur_attr = {cur_attr[7:4], fg_map[(sgr_code - CODE_FG_LO) * 4 +: 4]};
            end
            consumed = 1'b1;
          end
        end
      end
      default: parse_state = MODE_TEXT;
    endcase
    // a broken sequence falls through and the byte is taken as text
    if (!consumed) begin
      if (b == BYTE_ESC) begin
        parse_state = MODE_ESC;
      end else if (cursor >= CELLS) begin
        r.write_enable = 1'b1;
        r.cell_index   = CUR_W'(CELLS - 1);
        r.glyph        = BYTE_ERRMARK;
        r.attribute    = err_attr;
        r.error_flag   = 1'b1;
      end else if (b == BYTE_NEWLINE) begin
        cursor = (cursor / SCREEN_COLS + 1) * SCREEN_COLS;
      end else begin
        r.write_enable = 1'b1;
        r.cell_index   = CUR_W'(cursor);
        r.glyph        = (b == BYTE_BACKSPACE) ? BYTE_SPACE : b;
        r.attribute    = cur_attr;
        if (b != BYTE_BACKSPACE) cursor++;
      end
    end
    r.cursor_pos = CUR_W'(cursor);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_attr   = DEFAULT_ATTR_RST;
      fg_map      = FG_MAP_RST;
      err_attr    = ERROR_ATTR_RST;
      parse_state = MODE_TEXT;
      sgr_code    = '0;
      cur_attr    = DEFAULT_ATTR_RST;
      cursor      = 0;
      writes_due.delete();
      writes_due_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_DEFAULT_ATTR: dflt_attr = pwdata_i[7:0];
          REG_FG_MAP:       fg_map = pwdata_i;
          REG_ERROR_ATTR:   err_attr = pwdata_i[7:0];
          default: ;
        endcase
      end
      // results pass through the output register before they leave, so check before predicting
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (writes_due.size() == 0) begin
          note_mismatch("result count beyond accepted bytes", results_seen, 0);
        end else begin
          want = writes_due.pop_front();
          if (write_enable_i !== want.write_enable)
            note_mismatch("write_enable", write_enable_i, want.write_enable);
          if (cell_index_i !== want.cell_index)
            note_mismatch("cell_index", cell_index_i, want.cell_index);
          if (glyph_i !== want.glyph)
            note_mismatch("glyph", glyph_i, want.glyph);
          if (attribute_i !== want.attribute)
            note_mismatch("attribute", attribute_i, want.attribute);
          if (cursor_pos_i !== want.cursor_pos)
            note_mismatch("cursor_pos", cursor_pos_i, want.cursor_pos);
          if (error_flag_i !== want.error_flag)
            note_mismatch("error_flag", error_flag_i, want.error_flag);
        end
      end
      if (in_valid_i && !in_stall_i)
        writes_due.push_back(predict_cell_write(char_byte_i, set_position_i, pos_x_i, pos_y_i));
      writes_due_o <= writes_due.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// top of the text console writer bench: clock, reset, byte stream and register
// stimulus, receiver stalls, watchdog and verdict
// depends on tcacw_pkg, text_console_ansi_color_writer and console_write_checker
module testbench;
  import tcacw_pkg::*;

  localparam int unsigned IDLE_PCT       = 18;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned PHASE_ITEMS    = 500;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        char_byte_i = '0;
  logic              set_position_i = 1'b0;
  logic [7:0]        pos_x_i = '0;
  logic [7:0]        pos_y_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              write_enable_o;
  logic [CUR_W-1:0]  cell_index_o;
  logic [7:0]        glyph_o;
  logic [7:0]        attribute_o;
  logic [CUR_W-1:0]  cursor_pos_o;
  logic              error_flag_o;

  int unsigned writes_due;
  int unsigned mismatches;
  int unsigned bytes_sent = 0;
  int unsigned sgr_count = 0;
  int unsigned position_loads = 0;
  int unsigned stalled_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_served = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  text_console_ansi_color_writer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_byte_i    (char_byte_i),
    .set_position_i (set_position_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_enable_o (write_enable_o),
    .cell_index_o   (cell_index_o),
    .glyph_o        (glyph_o),
    .attribute_o    (attribute_o),
    .cursor_pos_o   (cursor_pos_o),
    .error_flag_o   (error_flag_o)
  );

  console_write_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .char_byte_i    (char_byte_i),
    .set_position_i (set_position_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_enable_i (write_enable_o),
    .cell_index_i   (cell_index_o),
    .glyph_i        (glyph_o),
    .attribute_i    (attribute_o),
    .cursor_pos_i   (cursor_pos_o),
    .error_flag_i   (error_flag_o),
    .writes_due_o   (writes_due),
    .mismatches_o   (mismatches)
  );

  // receiver: random stalls, plus one long hold so the block backs up
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == WATCHDOG_LIMIT) begin
      $display("no request accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  task automatic offer_byte(input logic [7:0] b, input logic load,
                            input logic [7:0] x, input logic [7:0] y);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    char_byte_i    <= b;
    set_position_i <= load;
    pos_x_i        <= x;
    pos_y_i        <= y;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    if (load) position_loads++;
  endtask

  task automatic offer_char(input logic [7:0] b);
    offer_byte(b, 1'b0, 8'($urandom), 8'($urandom));
  endtask

  task automatic push_sgr(input string digits);
    offer_char(BYTE_ESC);
    offer_char(BYTE_LBRACKET);
    for (int i = 0; i < digits.len(); i++) offer_char(8'(digits[i]));
    offer_char(BYTE_M);
    sgr_count++;
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // every byte gives one result, so an empty backlog means the block is idle
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (writes_due != 0);
  endtask

  task automatic configure(input logic [7:0] dflt, input logic [31:0] fg,
                           input logic [7:0] err);
    settle();
    apb_write(REG_DEFAULT_ATTR, {24'd0, dflt});
    apb_write(REG_FG_MAP, fg);
    apb_write(REG_ERROR_ATTR, {24'd0, err});
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    string       digits;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        case ($urandom_range(9))
          0:       digits = "0";
          1:       digits = "";
          2:       digits = $sformatf("%0d", $urandom_range(999));
          3:       digits = $sformatf("%0d", $urandom);
          default: digits = $sformatf("%0d", CODE_FG_LO + $urandom_range(7));
        endcase
        push_sgr(digits);
      end else if (pick < 24) begin
        // broken sequence: junk right after the introducer or inside the digits
        offer_char(BYTE_ESC);
        if ($urandom_range(1)) begin
          offer_char(BYTE_LBRACKET);
          offer_char(8'($urandom_range(BYTE_DIGIT_LO, BYTE_DIGIT_HI)));
        end
        offer_char(8'($urandom));
      end else if (pick < 32) begin
        if ($urandom_range(4) == 0)
          offer_byte(8'($urandom), 1'b1, 8'($urandom), 8'($urandom));
        else
          offer_byte(8'($urandom), 1'b1, 8'($urandom_range(SCREEN_COLS - 1)),
                     8'($urandom_range(SCREEN_ROWS - 1)));
      end else if (pick < 40) begin
        offer_char(BYTE_NEWLINE);
      end else if (pick < 44) begin
        offer_char(BYTE_BACKSPACE);
      end else begin
        offer_char(8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_byte(8'h00, 1'b1, 8'd0, 8'd0);
    offer_char(BYTE_BACKSPACE);
    push_sgr("37");
    push_sgr("");
    offer_char(BYTE_ESC);
    offer_char("X");
    offer_char(BYTE_ESC);
    offer_char(BYTE_LBRACKET);
    offer_char("4");
    offer_char("Z");
    push_sgr("999");
    // newline on the bottom row parks the cursor past the screen
    offer_byte(BYTE_NEWLINE, 1'b1, 8'd0, 8'(SCREEN_ROWS - 1));
    offer_char(BYTE_BACKSPACE);
    offer_byte(8'hFF, 1'b1, 8'(SCREEN_COLS - 1), 8'(SCREEN_ROWS - 1));
    offer_byte("x", 1'b1, 8'(SCREEN_COLS), 8'(SCREEN_ROWS));
    offer_char(BYTE_ESC);
    offer_byte(BYTE_LBRACKET, 1'b1, 8'd5, 8'd5);

    random_traffic(PHASE_ITEMS);

    configure(8'h00, 32'h0000_0000, 8'h00);
    calm = 1'b1;
    random_traffic(PHASE_ITEMS / 2);
    calm = 1'b0;
    random_traffic(PHASE_ITEMS / 2);

    configure(8'hFF, 32'hFFFF_FFFF, 8'hFF);
    random_traffic(PHASE_ITEMS / 2);
    hold_req = 1'b1;
    random_traffic(PHASE_ITEMS / 2);

    configure(8'($urandom), $urandom, 8'($urandom));
    random_traffic(PHASE_ITEMS);

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d bytes: %0d color sequences, %0d cursor loads, 4 register settings",
             bytes_sent, sgr_count, position_loads);
    $display("one %0d-cycle receiver hold with the byte stream backed up", HOLD_CYCLES);
    if (mismatches == 0 && writes_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/tcacw_pkg.sv
sv/tcacw_core.sv
sv/tcacw_skid.sv
sv/text_console_ansi_color_writer.sv
test/console_write_checker.sv
test/testbench.sv
